/* sv/rme_pkg.sv */
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by rme_mulmod and rsa_modular_exponentiation.

package rme_pkg;

    localparam int MOD_WIDTH_DEF   = 32;
    localparam int DATA_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

/* sv/rsa_modular_exponentiation.sv */
// Top level: config registers, square-and-multiply sequencer, output register.
// Depends on rme_pkg and rme_mulmod.

// Modular exponentiation: power_mod = base ^ exponent mod modulus.
// Configuration: write modulus (index 0) or exponent (index 1) on the cfg
//   channel; cfg_ready is always high. Write only while the block is idle.
// Input: one base word is taken when in_valid is high and in_stall is low.
//   in_stall stays high from acceptance until the result is loaded into the
//   output register, so one word is in work at a time.
// Operation: the base is first reduced mod modulus, then each of the MOD_WIDTH
//   exponent bits costs one squaring and, for a set bit, one multiply, all on the
//   single bit-serial modular multiplier. Exponent zero or modulus below two skip
//   the multiplier and go straight to the output register.
// Output: out_valid holds with power_mod until out_stall is low. While a result
//   waits, the next word may be accepted and computed; it is loaded only once
//   the output register is free.
// Reset: modulus = 2, exponent = 1, no word in flight, out_valid low.

module rsa_modular_exponentiation #(
    parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rme_pkg::DATA_WIDTH-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rme_pkg::DATA_WIDTH-1:0]       base,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rme_pkg::DATA_WIDTH-1:0]       power_mod
);

    localparam int CW = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] exponent_reg;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        bit_reg, bit_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_WIDTH-1:0] out_reg, out_next;

    logic                 mm_start;
    logic [MOD_WIDTH-1:0] mm_a;
    logic [MOD_WIDTH-1:0] mm_b;
    rme_pkg::mm_status_t  mm_status;
    logic [MOD_WIDTH-1:0] mm_result;
    logic                 in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_WIDTH'(2);
            exponent_reg <= MOD_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rme_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data[MOD_WIDTH-1:0];
                rme_pkg::CFG_EXPONENT: exponent_reg <= cfg_data[MOD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    rme_mulmod #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .op_a   (mm_a),
        .op_b   (mm_b),
        .op_m   (modulus_reg),
        .status (mm_status),
        .result (mm_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        mm_start       = 1'b0;
        mm_a           = mm_result;
        mm_b           = mm_result;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (exponent_reg == '0)
                    begin
                        res_next   = MOD_WIDTH'(1);
                        state_next = ST_DONE;
                    end
                    else if (modulus_reg < MOD_WIDTH'(2))
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // base mod m: multiply by one
                        mm_start   = 1'b1;
                        mm_a       = MOD_WIDTH'(1);
                        mm_b       = base[MOD_WIDTH-1:0];
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (mm_status.done)
                begin
                    b_next     = mm_result;
                    bit_next   = CW'(MOD_WIDTH - 1);
                    // acc starts at 1, so the first square is 1
                    mm_start   = 1'b1;
                    mm_a       = MOD_WIDTH'(1);
                    mm_b       = MOD_WIDTH'(1);
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_status.done)
                begin
                    if (exponent_reg[bit_reg])
                    begin
                        mm_start   = 1'b1;
                        mm_b       = b_reg;
                        state_next = ST_MUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        res_next   = mm_result;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                        mm_start = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (mm_status.done)
                begin
                    if (bit_reg == '0)
                    begin
                        res_next   = mm_result;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        mm_start   = 1'b1;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign power_mod = rme_pkg::DATA_WIDTH'(out_reg);

endmodule

/* sv/rme_mulmod.sv */
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of b per cycle.
// Requires a < m and m >= 2. Depends on rme_pkg.

module rme_mulmod #(
    parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] op_a,
    input  logic [MOD_WIDTH-1:0] op_b,
    input  logic [MOD_WIDTH-1:0] op_m,
    output rme_pkg::mm_status_t  status,
    output logic [MOD_WIDTH-1:0] result
);

    localparam int CW = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;
    logic [MOD_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;

    logic [MOD_WIDTH+1:0] t;
    logic [MOD_WIDTH+1:0] m1;
    logic [MOD_WIDTH+1:0] m2;
    logic [MOD_WIDTH+1:0] t_red;

    // r < m and a < m, so 2r + a < 3m: at most two subtractions of m
    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + (b_reg[MOD_WIDTH-1] ? {2'b00, a_reg} : '0);
        m1 = {2'b00, m_reg};
        m2 = {1'b0, m_reg, 1'b0};
        if (t >= m2)
        begin
            t_red = t - m2;
        end
        else if (t >= m1)
        begin
            t_red = t - m1;
        end
        else
        begin
            t_red = t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (busy_reg)
        begin
            r_next = t_red[MOD_WIDTH-1:0];
            b_next = {b_reg[MOD_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(MOD_WIDTH - 1);
            r_next    = '0;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = op_m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule

/* tb/tb_rsa_modular_exponentiation.sv */
// Testbench for rsa_modular_exponentiation: directed and random base words
// under several modulus/exponent settings, checked against an in-bench predictor.
// Depends on rme_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_rsa_modular_exponentiation;

    localparam int LONG_HOLD      = 6000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 2500;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [rme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = rme_pkg::CFG_MODULUS;
    logic [rme_pkg::DATA_WIDTH-1:0]      cfg_data  = '0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    logic [rme_pkg::DATA_WIDTH-1:0]      base      = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [rme_pkg::DATA_WIDTH-1:0]      power_mod;

    // bench copy of the block's registers
    logic [rme_pkg::DATA_WIDTH-1:0] cur_modulus  = 32'd2;
    logic [rme_pkg::DATA_WIDTH-1:0] cur_exponent = 32'd1;

    logic [rme_pkg::DATA_WIDTH-1:0] pending_base_q[$];
    logic [rme_pkg::DATA_WIDTH-1:0] expected_power_q[$];

    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done;
    int hold_left;
    int error_count    = 0;
    int quiet_cycles;

    rsa_modular_exponentiation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .power_mod (power_mod)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // square-and-multiply, MSB first; exponent zero gives 1 before any reduction
    function automatic logic [rme_pkg::DATA_WIDTH-1:0] calc_power_mod(
        input logic [rme_pkg::DATA_WIDTH-1:0] b,
        input logic [rme_pkg::DATA_WIDTH-1:0] e,
        input logic [rme_pkg::DATA_WIDTH-1:0] m
    );
        logic [63:0] acc;
        logic [63:0] bb;
        logic [63:0] mm;
        acc = 64'd1;
        if (e == '0)
            return 32'd1;
        if (m < 32'd2)
            return '0;
        mm = {32'd0, m};
        bb = {32'd0, b} % mm;
        for (int i = rme_pkg::DATA_WIDTH - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % mm;
            if (e[i])
                acc = (acc * bb) % mm;
        end
        return acc[rme_pkg::DATA_WIDTH-1:0];
    endfunction

    function automatic logic [rme_pkg::DATA_WIDTH-1:0] pick_base(
        input logic [rme_pkg::DATA_WIDTH-1:0] m
    );
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'd1;
            2:       return m - 32'd1;
            3:       return m;
            4:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // driver: one word offered at a time, held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            base     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_power_q.push_back(calc_power_mod(base, cur_exponent, cur_modulus));
            if (!in_valid || !in_stall)
            begin
                if (pending_base_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    base     <= pending_base_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word and drives out_stall
    always @(posedge clk or negedge rst_n)
    begin
        logic [rme_pkg::DATA_WIDTH-1:0] want;
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_power_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, power_mod);
                    error_count++;
                end
                else
                begin
                    want = expected_power_q.pop_front();
                    if (power_mod !== want)
                    begin
                        $display("%0t: power_mod mismatch, expected %h, got %h",
                                 $time, want, power_mod);
                        error_count++;
                    end
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                hold_left      <= LONG_HOLD;
                long_hold_done <= 1'b1;
                out_stall      <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words still expected",
                     $time, expected_power_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [rme_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [rme_pkg::DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rme_pkg::CFG_MODULUS)
            cur_modulus = data;
        else
            cur_exponent = data;
    endtask

    task automatic set_keys(input logic [rme_pkg::DATA_WIDTH-1:0] m,
                            input logic [rme_pkg::DATA_WIDTH-1:0] e);
        write_reg(rme_pkg::CFG_MODULUS, m);
        write_reg(rme_pkg::CFG_EXPONENT, e);
        @(negedge clk);
    endtask

    task automatic random_keys();
        logic [rme_pkg::DATA_WIDTH-1:0] m;
        logic [rme_pkg::DATA_WIDTH-1:0] e;
        case ($urandom_range(7))
            0:       m = 32'hFFFF_FFFF;
            1:       m = 32'd2;
            2:       m = $urandom_range(1000, 2);
            3:       m = 32'd3233;
            default: m = $urandom;
        endcase
        if (m < 32'd2)
            m = 32'd2;
        case ($urandom_range(7))
            0:       e = '0;
            1:       e = 32'd1;
            2:       e = 32'd65537;
            3:       e = 32'hFFFF_FFFF;
            default: e = $urandom;
        endcase
        set_keys(m, e);
    endtask

    // wait until every offered word has come back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_base_q.size() != 0 || in_valid || expected_power_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        @(negedge clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        for (int i = 0; i < count; i++)
            pending_base_q.push_back(pick_base(cur_modulus));
    endtask

    task automatic queue_word(input logic [rme_pkg::DATA_WIDTH-1:0] b);
        @(negedge clk);
        pending_base_q.push_back(b);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset keys: modulus 2, exponent 1
        queue_word(32'd0);
        queue_word(32'd1);
        queue_word(32'd2);
        queue_word(32'd3);
        queue_word(32'hFFFF_FFFF);
        drain();

        set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(32'd0);
        queue_word(32'd1);
        queue_word(32'hFFFF_FFFE);
        queue_word(32'hFFFF_FFFF);
        queue_word(32'h1234_5678);
        drain();

        // zero exponent returns 1 even for modulus one or zero
        set_keys(32'd1, 32'd0);
        queue_word(32'd0);
        queue_word(32'd5);
        drain();
        set_keys(32'd0, 32'd0);
        queue_word(32'd7);
        drain();

        // modulus below two with a nonzero exponent gives 0
        set_keys(32'd1, 32'd3);
        queue_word(32'd9);
        drain();
        set_keys(32'd0, 32'd65537);
        queue_word(32'd9);
        drain();

        // textbook key pair, encrypt then decrypt
        set_keys(32'd3233, 32'd17);
        queue_word(32'd65);
        drain();
        set_keys(32'd3233, 32'd2753);
        queue_word(32'd2790);
        drain();

        random_keys();
        set_idling(0, 0);
        queue_random(22);
        drain();

        random_keys();
        set_idling(86, 0);
        queue_random(25);
        drain();

        random_keys();
        set_idling(0, 86);
        queue_random(25);
        drain();

        random_keys();
        set_idling(7, 7);
        queue_random(22);
        drain();

        // long receiver hold-off with the sender pushing: input backs up
        random_keys();
        set_idling(0, 0);
        queue_random(15);
        long_hold_req = 1'b1;
        drain();

        // sender goes quiet mid-phase until the block is empty
        random_keys();
        set_idling(7, 7);
        queue_random(8);
        drain();
        queue_random(7);
        drain();

        set_idling(0, 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_power_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* rsa_modular_exponentiation.f */
sv/rme_pkg.sv
sv/rme_mulmod.sv
sv/rsa_modular_exponentiation.sv
tb/tb_rsa_modular_exponentiation.sv
